// ===== hw/rtl/lwf_pkg.sv =====
// Shared types, constants and elaboration-time helpers for the local window
// fingerprint block. Depends on nothing; every other RTL file imports it.
`default_nettype none

package lwf_pkg;

  localparam int WIN_BITS          = 49;
  localparam int WIN_IDX_W         = $clog2(WIN_BITS);
  localparam int DEF_WINDOW_RADIUS = 3;
  localparam int NUM_ORIENT        = 8;
  localparam int CNT_W             = 4;
  localparam int HASH_W            = 32;
  localparam int TREE_FANIN        = 4;

  typedef logic [WIN_BITS-1:0] win_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [HASH_W-1:0]   hash_t;

  localparam hash_t HASH_PRIME = 32'd312101;

  // Orientations that carry the axis point (0,d) onto the four axis directions.
  localparam int AXIS_ORIENT [4] = '{0, 2, 4, 5};

  // Control that travels alongside each request through the pipeline.
  typedef struct packed {
    logic valid;
    logic seen;
  } lwf_ctl_t;

  function automatic int num_counts(int radius);
    return 4 * radius * radius - 2 * radius;
  endfunction

  // Index of the first count that belongs to ring distance d.
  function automatic int ring_base(int d);
    return 4 * d * (d - 1) - 6 * (d - 1);
  endfunction

  function automatic int level_size(int n, int lvl);
    int s;
    s = n;
    for (int i = 0; i < lvl; i++) s = (s + TREE_FANIN - 1) / TREE_FANIN;
    return s;
  endfunction

  function automatic int tree_levels(int n);
    int s;
    int l;
    s = n;
    l = 0;
    while (s > 1) begin
      s = (s + TREE_FANIN - 1) / TREE_FANIN;
      l++;
    end
    return l;
  endfunction

  function automatic int level_offset(int n, int lvl);
    int off;
    off = 0;
    for (int i = 0; i < lvl; i++) off += level_size(n, i);
    return off;
  endfunction

  function automatic int tree_nodes(int n);
    return level_offset(n, tree_levels(n) + 1);
  endfunction

  // Count stage, product stage, then one register per adder tree level.
  function automatic int lwf_latency(int radius);
    return tree_levels(num_counts(radius)) + 2;
  endfunction

  function automatic hash_t pow_mod(int e);
    hash_t p;
    p = 32'd1;
    for (int i = 0; i < e; i++) p = p * HASH_PRIME;
    return p;
  endfunction

  function automatic int orient_row(int r, int c, int o);
    int a;
    a = ((o & 4) != 0) ? c : r;
    if ((o & 1) != 0) a = -a;
    return a;
  endfunction

  function automatic int orient_col(int r, int c, int o);
    int b;
    b = ((o & 4) != 0) ? r : c;
    if ((o & 2) != 0) b = -b;
    return b;
  endfunction

  // Composition f . g of two orientations.
  function automatic int compose(int f, int g);
    int v;
    v = g & 7;
    if ((f & 4) != 0) v = ((v & 1) << 1) | ((v & 2) >> 1) | ((v & 4) ^ 4);
    return (v ^ (f & 3)) & 7;
  endfunction

  // Offsets that fall outside the carried bits read as land.
  function automatic logic cell_bit(win_t win, int radius, int dr, int dc);
    int idx;
    idx = (dr + radius) * (2 * radius + 1) + (dc + radius);
    if (idx < 0 || idx >= WIN_BITS) return 1'b0;
    return win[idx[WIN_IDX_W-1:0]];
  endfunction

  function automatic cnt_t popcount8(logic [7:0] v);
    cnt_t n;
    n = '0;
    for (int i = 0; i < 8; i++) n = n + cnt_t'(v[i]);
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lwf_mismatch.sv =====
// First pipeline stage: all mismatch counts of one window, registered.
// Depends on lwf_pkg for the orientation helpers and the control struct.
`default_nettype none

module lwf_mismatch import lwf_pkg::*; #(
  parameter int WINDOW_RADIUS = DEF_WINDOW_RADIUS,
  parameter int NUM_COUNTS    = num_counts(WINDOW_RADIUS)
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  win_t      water_window,
  input  logic      window_seen,
  output cnt_t      counts [NUM_COUNTS],
  output lwf_ctl_t  ctl
);

  cnt_t cnt_next [NUM_COUNTS];
  logic center;

  assign center = cell_bit(water_window, WINDOW_RADIUS, 0, 0);

  for (genvar d = 1; d <= WINDOW_RADIUS; d++) begin : g_ring
    localparam int BASE = ring_base(d);
    logic [3:0] diag_mis;
    logic [3:0] axis_mis;

    for (genvar o = 0; o < 4; o++) begin : g_pt
      assign diag_mis[o] = center ^ cell_bit(water_window, WINDOW_RADIUS,
                                             orient_row(d, d, o), orient_col(d, d, o));
      assign axis_mis[o] = center ^ cell_bit(water_window, WINDOW_RADIUS,
                                             orient_row(0, d, AXIS_ORIENT[o]),
                                             orient_col(0, d, AXIS_ORIENT[o]));
    end

    assign cnt_next[BASE]     = popcount8({4'b0, diag_mis});
    assign cnt_next[BASE + 1] = popcount8({4'b0, axis_mis});

    for (genvar k = 1; k < d; k++) begin : g_off
      localparam int KBASE = BASE + 2 + NUM_ORIENT * (k - 1);
      logic [NUM_ORIENT-1:0] w;

      for (genvar o = 0; o < NUM_ORIENT; o++) begin : g_img
        assign w[o] = cell_bit(water_window, WINDOW_RADIUS,
                               orient_row(d, k, o), orient_col(d, k, o));
      end

      assign cnt_next[KBASE] = popcount8(w ^ {NUM_ORIENT{center}});

      // Each relative orientation compares an image with its composed partner.
      for (genvar rel = 1; rel < NUM_ORIENT; rel++) begin : g_rel
        logic [NUM_ORIENT-1:0] mis;
        for (genvar o = 0; o < NUM_ORIENT; o++) begin : g_cmp
          assign mis[o] = w[o] ^ w[compose(o, rel)];
        end
        assign cnt_next[KBASE + rel] = popcount8(mis);
      end
    end
  end

  // An unseen window hashes to zero, so its counts are zeroed here.
  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_COUNTS; j++) begin
      counts[j] <= window_seen ? cnt_next[j] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.valid <= accept;
      ctl.seen  <= window_seen;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/local_window_fingerprint_top.sv =====
// Pipeline: count stage, power product stage, then one register per adder tree
// level; three adder levels at radius 3.
// Throughput: one request per cycle; busy is always low.
// Reset clears only the control bits (valid and seen) of the pipeline; results cannot be stalled.
// Top level of the local window fingerprint block; depends on lwf_pkg and
// lwf_mismatch.
`default_nettype none

module local_window_fingerprint_top import lwf_pkg::*; #(
  parameter int WINDOW_RADIUS = DEF_WINDOW_RADIUS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [48:0] water_window,
  input  logic        window_seen,
  output logic        done,
  output logic [31:0] fingerprint,
  output logic        computed
);

  localparam int NUM_COUNTS = num_counts(WINDOW_RADIUS);
  localparam int LEVELS     = tree_levels(NUM_COUNTS);
  localparam int NODES      = tree_nodes(NUM_COUNTS);
  localparam int PIPE       = LEVELS + 1;

  cnt_t     counts [NUM_COUNTS];
  lwf_ctl_t cnt_ctl;
  lwf_ctl_t ctl [PIPE];
  hash_t    node [NODES];

  assign busy = 1'b0;

  lwf_mismatch #(
    .WINDOW_RADIUS(WINDOW_RADIUS),
    .NUM_COUNTS   (NUM_COUNTS)
  ) u_mismatch (
    .clk         (clk),
    .rst         (rst),
    .accept      (start && !busy),
    .water_window(water_window),
    .window_seen (window_seen),
    .counts      (counts),
    .ctl         (cnt_ctl)
  );

  // Horner folding unrolled: count j is weighted by prime^(N-1-j) mod 2^32.
  for (genvar j = 0; j < NUM_COUNTS; j++) begin : g_prod
    localparam hash_t WEIGHT = pow_mod(NUM_COUNTS - 1 - j);
    always_ff @(posedge clk) begin
      node[j] <= hash_t'(counts[j]) * WEIGHT;
    end
  end

  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    localparam int SRC_OFF  = level_offset(NUM_COUNTS, l - 1);
    localparam int SRC_SIZE = level_size(NUM_COUNTS, l - 1);
    localparam int DST_OFF  = level_offset(NUM_COUNTS, l);
    localparam int DST_SIZE = level_size(NUM_COUNTS, l);

    for (genvar i = 0; i < DST_SIZE; i++) begin : g_node
      hash_t part [TREE_FANIN];
      hash_t sum;

      for (genvar c = 0; c < TREE_FANIN; c++) begin : g_leg
        if (i * TREE_FANIN + c < SRC_SIZE) begin : g_used
          assign part[c] = node[SRC_OFF + i * TREE_FANIN + c];
        end else begin : g_pad
          assign part[c] = '0;
        end
      end

      always_comb begin
        sum = '0;
        for (int c = 0; c < TREE_FANIN; c++) sum = sum + part[c];
      end

      always_ff @(posedge clk) begin
        node[DST_OFF + i] <= sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE; i++) ctl[i] <= '0;
    end else begin
      ctl[0] <= cnt_ctl;
      for (int i = 1; i < PIPE; i++) ctl[i] <= ctl[i-1];
    end
  end

  assign done        = ctl[PIPE-1].valid;
  assign computed    = ctl[PIPE-1].seen;
  assign fingerprint = node[NODES-1];

endmodule

`default_nettype wire

// ===== hw/rtl/lwf_checker.sv =====
// Port-level assertions for local_window_fingerprint_top and the bind that
// attaches them. Depends on lwf_pkg for the latency function.
`default_nettype none

module lwf_checker import lwf_pkg::*; #(
  parameter int WINDOW_RADIUS = DEF_WINDOW_RADIUS
) (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        window_seen,
  input logic        done,
  input logic [31:0] fingerprint,
  input logic        computed
);

  localparam int LATENCY = lwf_latency(WINDOW_RADIUS);

  // Every accepted request produces exactly one result after the fixed latency.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted request produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching request");

  a_flag_tracks: assert property (@(posedge clk) disable iff (rst)
    done |-> (computed == $past(window_seen, LATENCY)))
    else $error("computed flag does not match the request's seen flag");

  a_unseen_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !computed) |-> (fingerprint == 32'd0))
    else $error("unseen window gave a nonzero fingerprint");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe after reset");

endmodule

bind local_window_fingerprint_top lwf_checker #(
  .WINDOW_RADIUS(WINDOW_RADIUS)
) u_lwf_checker (.*);

`default_nettype wire
